[design/dest_pkg.sv]
// Types and constants shared by the delayed event slot table.
package dest_pkg;

    // Input transaction modes.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ADD_STATUS = 2'd0;
    localparam logic [1:0] KIND_DELIVERY   = 2'd1;
    localparam logic [1:0] KIND_NONE_DUE   = 2'd2;
    localparam logic [1:0] KIND_FLUSH_DONE = 2'd3;

    // Fixed delay added to every event, in milliseconds.
    localparam logic [31:0] BASE_DELAY = 32'd300;

    // Most deliveries that one tick may release, and a counter that holds it.
    localparam int unsigned MAX_OUT = 8;
    localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

    // One stored slot entry.
    typedef struct packed {
        logic [15:0] target;
        logic [7:0]  kind;
        logic [15:0] handle;
        logic [31:0] due;
    } slot_entry_t;

endpackage

[design/delayed_event_slot_table.sv]
// An add or tick walks all SLOTS entries, one a cycle while its scan is not stalled, then
// gives its final result from the finish state; a flush clears every slot and goes straight there.
// Throughput: one item at a time; the next is taken once the block is back in idle.
// A tick that releases several events stalls its scan while the result register is full.
// Reset (aresetn, synchronous, active low) empties every slot and clears the output.
// Slot payloads sit in a one-port-read, one-port-write memory; busy bits are flip-flops.
module delayed_event_slot_table #(
    parameter int unsigned SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_target_id,
    input  logic [7:0]  s_event_kind,
    input  logic [15:0] s_event_handle,
    input  logic [8:0]  s_jitter_ms,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_accepted,
    output logic [15:0] m_out_target,
    output logic [15:0] m_out_event,
    output logic        m_last
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [dest_pkg::CNT_W-1:0] CNT_MAX = dest_pkg::CNT_W'(dest_pkg::MAX_OUT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Slot payload memory.
    dest_pkg::slot_entry_t slot_mem [SLOTS];

    logic [1:0]                 state_reg, state_next;
    logic [1:0]                 mode_reg, mode_next;
    logic [15:0]                tgt_reg, tgt_next;
    logic [7:0]                 kind_reg, kind_next;
    logic [15:0]                handle_reg, handle_next;
    logic [8:0]                 jitter_reg, jitter_next;
    logic [31:0]                now_reg, now_next;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic [SLOTS-1:0]           busy_reg, busy_next;
    logic                       dup_reg, dup_next;
    logic                       free_found_reg, free_found_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [dest_pkg::CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [15:0]                pend_target_reg, pend_target_next;
    logic [15:0]                pend_event_reg, pend_event_next;
    dest_pkg::slot_entry_t      rd_data_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [1:0]                 m_kind_reg, m_kind_next;
    logic                       m_accepted_reg, m_accepted_next;
    logic [15:0]                m_target_reg, m_target_next;
    logic [15:0]                m_event_reg, m_event_next;
    logic                       m_last_reg, m_last_next;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_idx;
    logic                       wr_en;
    dest_pkg::slot_entry_t      wr_data;
    logic                       out_free;
    logic                       slot_busy;
    logic                       hit;
    logic                       advance;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_accepted   = m_accepted_reg;
    assign m_out_target = m_target_reg;
    assign m_out_event  = m_event_reg;
    assign m_last       = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign slot_busy = busy_reg[scan_idx_reg];

    // Entry written by a successful add.
    always_comb begin
        wr_data.target = tgt_reg;
        wr_data.kind   = kind_reg;
        wr_data.handle = handle_reg;
        wr_data.due    = now_reg + dest_pkg::BASE_DELAY + 32'(jitter_reg);
    end

    // Scan sequencer and result generation.
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        tgt_next         = tgt_reg;
        kind_next        = kind_reg;
        handle_next      = handle_reg;
        jitter_next      = jitter_reg;
        now_next         = now_reg;
        scan_idx_next    = scan_idx_reg;
        busy_next        = busy_reg;
        dup_next         = dup_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_target_next = pend_target_reg;
        pend_event_next  = pend_event_reg;
        m_valid_next     = m_valid_reg;
        m_kind_next      = m_kind_reg;
        m_accepted_next  = m_accepted_reg;
        m_target_next    = m_target_reg;
        m_event_next     = m_event_reg;
        m_last_next      = m_last_reg;
        rd_en            = 1'b0;
        rd_idx           = scan_idx_reg;
        wr_en            = 1'b0;
        hit              = 1'b0;
        advance          = 1'b1;

        // The held result leaves when the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    tgt_next    = s_target_id;
                    kind_next   = s_event_kind;
                    handle_next = s_event_handle;
                    jitter_next = s_jitter_ms;
                    now_next    = s_now_ms;
                    case (s_mode)
                        dest_pkg::MODE_ADD, dest_pkg::MODE_TICK: begin
                            rd_en           = 1'b1;
                            rd_idx          = '0;
                            scan_idx_next   = '0;
                            dup_next        = 1'b0;
                            free_found_next = 1'b0;
                            hit_cnt_next    = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_EVAL;
                        end
                        dest_pkg::MODE_FLUSH: begin
                            busy_next  = '0;
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EVAL: begin
                if (mode_reg == dest_pkg::MODE_ADD) begin
                    // Duplicate check on busy slots, first free slot otherwise.
                    if (slot_busy) begin
                        if (rd_data_reg.target == tgt_reg && rd_data_reg.kind == kind_reg) begin
                            dup_next = 1'b1;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                end else begin
                    // A due slot is held back one step so the final one can be marked.
                    hit = slot_busy && (rd_data_reg.due < now_reg) && (hit_cnt_reg != CNT_MAX);
                    if (hit) begin
                        if (pend_valid_reg) begin
                            if (out_free) begin
                                m_valid_next    = 1'b1;
                                m_kind_next     = dest_pkg::KIND_DELIVERY;
                                m_accepted_next = 1'b0;
                                m_target_next   = pend_target_reg;
                                m_event_next    = pend_event_reg;
                                m_last_next     = 1'b0;
                            end else begin
                                advance = 1'b0;
                            end
                        end
                        if (advance) begin
                            pend_valid_next         = 1'b1;
                            pend_target_next        = rd_data_reg.target;
                            pend_event_next         = rd_data_reg.handle;
                            busy_next[scan_idx_reg] = 1'b0;
                            hit_cnt_next            = hit_cnt_reg + 1'b1;
                        end
                    end
                end

                // Move on to the next slot, or finish after the last one.
                if (advance) begin
                    if (scan_idx_reg == LAST_IDX) begin
                        state_next = ST_FIN;
                    end else begin
                        rd_en         = 1'b1;
                        rd_idx        = scan_idx_reg + 1'b1;
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_accepted_next = 1'b0;
                    m_target_next   = '0;
                    m_event_next    = '0;
                    m_last_next     = 1'b1;
                    case (mode_reg)
                        dest_pkg::MODE_ADD: begin
                            m_kind_next = dest_pkg::KIND_ADD_STATUS;
                            if (!dup_reg && free_found_reg) begin
                                m_accepted_next         = 1'b1;
                                wr_en                   = 1'b1;
                                busy_next[free_idx_reg] = 1'b1;
                            end
                        end
                        dest_pkg::MODE_TICK: begin
                            if (pend_valid_reg) begin
                                m_kind_next   = dest_pkg::KIND_DELIVERY;
                                m_target_next = pend_target_reg;
                                m_event_next  = pend_event_reg;
                            end else begin
                                m_kind_next = dest_pkg::KIND_NONE_DUE;
                            end
                        end
                        default: begin
                            m_kind_next = dest_pkg::KIND_FLUSH_DONE;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        tgt_reg         <= tgt_next;
        kind_reg        <= kind_next;
        handle_reg      <= handle_next;
        jitter_reg      <= jitter_next;
        now_reg         <= now_next;
        scan_idx_reg    <= scan_idx_next;
        dup_reg         <= dup_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        hit_cnt_reg     <= hit_cnt_next;
        pend_valid_reg  <= pend_valid_next;
        pend_target_reg <= pend_target_next;
        pend_event_reg  <= pend_event_next;
        m_kind_reg      <= m_kind_next;
        m_accepted_reg  <= m_accepted_next;
        m_target_reg    <= m_target_next;
        m_event_reg     <= m_event_next;
        m_last_reg      <= m_last_next;
    end

    // Slot memory: registered read, single write port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[free_idx_reg] <= wr_data;
        end
    end

endmodule

[test/tb_top.sv]
// Self-checking testbench for the delayed event slot table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 8;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RUN_LIMIT_NS = 3_000_000;

    // One input transaction, field for field.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] target_id;
        logic [7:0]  event_kind;
        logic [15:0] event_handle;
        logic [8:0]  jitter_ms;
        logic [31:0] now_ms;
    } table_op_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [15:0] target;
        logic [15:0] handle;
        logic        last;
    } table_outcome_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = dest_pkg::MODE_ADD;
    logic [15:0] s_target_id = '0;
    logic [7:0]  s_event_kind = '0;
    logic [15:0] s_event_handle = '0;
    logic [8:0]  s_jitter_ms = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic        m_accepted;
    logic [15:0] m_out_target;
    logic [15:0] m_out_event;
    logic        m_last;

    // Shadow copy of the slot table.
    logic        shadow_busy   [SLOTS];
    logic [15:0] shadow_target [SLOTS];
    logic [7:0]  shadow_kind   [SLOTS];
    logic [15:0] shadow_handle [SLOTS];
    logic [31:0] shadow_due    [SLOTS];

    table_outcome_t table_outcomes[$];

    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 45;
    logic        hold_active = 1'b0;
    event        start_receiver_hold;
    logic [31:0] traffic_now;

    int unsigned mismatch_count = 0;
    int unsigned ops_sent = 0;
    int unsigned results_seen = 0;
    int unsigned deliveries_seen = 0;
    int unsigned adds_stored = 0;
    int unsigned adds_refused = 0;

    delayed_event_slot_table #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_target_id    (s_target_id),
        .s_event_kind   (s_event_kind),
        .s_event_handle (s_event_handle),
        .s_jitter_ms    (s_jitter_ms),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_accepted     (m_accepted),
        .m_out_target   (m_out_target),
        .m_out_event    (m_out_event),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still outstanding", table_outcomes.size());
        $display("FAILURE");
        $finish;
    end

    // Empties the shadow table, as reset and flush do.
    function automatic void clear_shadow_table();
        for (int i = 0; i < SLOTS; i++) begin
            shadow_busy[i]   = 1'b0;
            shadow_due[i]    = '1;
            shadow_target[i] = '0;
            shadow_kind[i]   = '0;
            shadow_handle[i] = '0;
        end
    endfunction

    // Applies one accepted transaction to the shadow table and queues its results.
    function automatic void apply_to_shadow_table(input table_op_t op);
        int free_idx;
        bit dup;
        int unsigned released;
        table_outcome_t r;
        free_idx = -1;
        dup = 1'b0;
        released = 0;
        r = '0;
        case (op.mode)
            dest_pkg::MODE_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_busy[i]) begin
                        if (shadow_target[i] == op.target_id &&
                            shadow_kind[i] == op.event_kind)
                            dup = 1'b1;
                    end else if (free_idx < 0) begin
                        free_idx = i;
                    end
                end
                r.kind = dest_pkg::KIND_ADD_STATUS;
                r.last = 1'b1;
                if (!dup && free_idx >= 0) begin
                    shadow_busy[free_idx]   = 1'b1;
                    shadow_target[free_idx] = op.target_id;
                    shadow_kind[free_idx]   = op.event_kind;
                    shadow_handle[free_idx] = op.event_handle;
                    shadow_due[free_idx]    = op.now_ms + dest_pkg::BASE_DELAY +
                                              32'(op.jitter_ms);
                    r.accepted = 1'b1;
                end
                table_outcomes.push_back(r);
            end
            dest_pkg::MODE_TICK: begin
                // Release due slots in slot order, plain unsigned compare.
                for (int i = 0; i < SLOTS && released < dest_pkg::MAX_OUT; i++) begin
                    if (shadow_busy[i] && shadow_due[i] < op.now_ms) begin
                        r = '0;
                        r.kind   = dest_pkg::KIND_DELIVERY;
                        r.target = shadow_target[i];
                        r.handle = shadow_handle[i];
                        table_outcomes.push_back(r);
                        released++;
                        shadow_busy[i] = 1'b0;
                        shadow_due[i]  = '1;
                    end
                end
                if (released == 0) begin
                    r = '0;
                    r.kind = dest_pkg::KIND_NONE_DUE;
                    r.last = 1'b1;
                    table_outcomes.push_back(r);
                end else begin
                    r = table_outcomes.pop_back();
                    r.last = 1'b1;
                    table_outcomes.push_back(r);
                end
            end
            dest_pkg::MODE_FLUSH: begin
                clear_shadow_table();
                r.kind = dest_pkg::KIND_FLUSH_DONE;
                r.last = 1'b1;
                table_outcomes.push_back(r);
            end
            default: begin
                // The unused mode leaves the table alone and gives no result.
            end
        endcase
    endfunction

    function automatic table_op_t add_op(input logic [15:0] tgt, input logic [7:0] kind,
                                         input logic [15:0] handle, input logic [8:0] jitter,
                                         input logic [31:0] now);
        table_op_t op;
        op = '{dest_pkg::MODE_ADD, tgt, kind, handle, jitter, now};
        return op;
    endfunction

    function automatic table_op_t tick_op(input logic [31:0] now);
        table_op_t op;
        op = '0;
        op.mode = dest_pkg::MODE_TICK;
        op.now_ms = now;
        return op;
    endfunction

    function automatic table_op_t flush_op();
        table_op_t op;
        op = '0;
        op.mode = dest_pkg::MODE_FLUSH;
        return op;
    endfunction

    // Offers one transaction, holds it until accepted, then predicts its results.
    task automatic send_op(input table_op_t op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= op.mode;
        s_target_id    <= op.target_id;
        s_event_kind   <= op.event_kind;
        s_event_handle <= op.event_handle;
        s_jitter_ms    <= op.jitter_ms;
        s_now_ms       <= op.now_ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_to_shadow_table(op);
        ops_sent++;
    endtask

    // Waits for every outstanding result, then for the block to settle.
    task automatic drain_outcomes();
        s_valid <= 1'b0;
        while (table_outcomes.size() != 0) @(posedge aclk);
        repeat (SLOTS + 4) @(posedge aclk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver readiness: random idling, or held low during a hold-off stretch.
    always @(posedge aclk) begin
        if (hold_active)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Hold-off stretch, counted here in clock cycles.
    initial begin
        forever begin
            @(start_receiver_hold);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // Compares every result transaction with the oldest prediction.
    always @(posedge aclk) begin : check_results
        table_outcome_t want;
        if (m_valid && m_ready) begin
            results_seen++;
            if (table_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d %s %0h %0h",
                         $time, m_kind, "target/event", m_out_target, m_out_event);
                mismatch_count++;
            end else begin
                want = table_outcomes.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_kind));
                check_field("accepted", 32'(want.accepted), 32'(m_accepted));
                check_field("out_target", 32'(want.target), 32'(m_out_target));
                check_field("out_event", 32'(want.handle), 32'(m_out_event));
                check_field("last", 32'(want.last), 32'(m_last));
                if (want.kind == dest_pkg::KIND_DELIVERY)
                    deliveries_seen++;
                else if (want.kind == dest_pkg::KIND_ADD_STATUS && want.accepted)
                    adds_stored++;
                else if (want.kind == dest_pkg::KIND_ADD_STATUS)
                    adds_refused++;
            end
        end
    end

    // One event, a tick on its exact due time, then one millisecond later.
    task automatic test_add_then_tick();
        send_op(add_op(16'h0000, 8'h00, 16'h0000, 9'd0, 32'd1000));
        send_op(tick_op(32'd1300));
        send_op(tick_op(32'd1301));
        drain_outcomes();
    endtask

    // Duplicate refusal, a full table, then one tick that empties all slots.
    task automatic test_duplicate_and_full();
        send_op(add_op(16'hFFFF, 8'hFF, 16'hFFFF, 9'd511, 32'd0));
        send_op(add_op(16'hFFFF, 8'hFF, 16'h1111, 9'd0, 32'd10));
        send_op(add_op(16'hFFFF, 8'hFE, 16'h0000, 9'd500, 32'd20));
        for (int i = 1; i <= 6; i++)
            send_op(add_op(16'(i), 8'(i), 16'($urandom), 9'($urandom_range(0, 511)), 32'(i)));
        send_op(add_op(16'h4242, 8'h42, 16'h4242, 9'd7, 32'd99));
        send_op(tick_op(32'hFFFF_FFFF));
        drain_outcomes();
    endtask

    // Due time wrapping past 2^32, flush, and the unused mode.
    task automatic test_wrap_flush_unused();
        table_op_t op;
        send_op(add_op(16'h1234, 8'h5A, 16'hBEEF, 9'd500, 32'hFFFF_FF00));
        send_op(tick_op(32'h0000_0220));
        send_op(tick_op(32'h0000_0221));
        send_op(add_op(16'h00FF, 8'h0F, 16'hFF00, 9'd0, 32'd5));
        send_op(flush_op());
        send_op(tick_op(32'hFFFF_FFFF));
        op = '1;
        op.mode = MODE_UNUSED;
        send_op(op);
        drain_outcomes();
    endtask

    // Mostly well-formed traffic on a moving time base, with some noise mixed in.
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_ops);
        table_op_t op;
        int unsigned counted;
        int unsigned pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted = 0;
        while (counted < n_ops) begin
            pick = $urandom_range(0, 99);
            op.target_id    = 16'($urandom);
            op.event_kind   = 8'($urandom);
            op.event_handle = 16'($urandom);
            op.jitter_ms    = 9'($urandom_range(0, 511));
            op.now_ms       = traffic_now;
            if (pick < 50) begin
                // Small pools of targets and kinds so duplicates show up.
                op.mode = dest_pkg::MODE_ADD;
                if ($urandom_range(0, 9) < 7) op.target_id = 16'($urandom_range(0, 3));
                if ($urandom_range(0, 9) < 7) op.event_kind = 8'($urandom_range(0, 2));
                traffic_now += 32'($urandom_range(0, 120));
            end else if (pick < 82) begin
                op.mode = dest_pkg::MODE_TICK;
                traffic_now += 32'($urandom_range(0, 400));
                op.now_ms = traffic_now;
            end else if (pick < 87) begin
                op.mode = dest_pkg::MODE_FLUSH;
            end else if (pick < 90) begin
                op.mode = MODE_UNUSED;
                op.now_ms = $urandom;
            end else begin
                op.mode = 2'($urandom_range(0, 2));
                op.now_ms = $urandom;
            end
            send_op(op);
            if (op.mode != MODE_UNUSED) counted++;
        end
        drain_outcomes();
    endtask

    // Receiver holds off while the sender keeps offering transactions.
    task automatic test_receiver_hold_off();
        ->start_receiver_hold;
        for (int k = 0; k < 20; k++) begin
            if (k % 5 == 4) begin
                traffic_now += 32'd1000;
                send_op(tick_op(traffic_now));
            end else begin
                send_op(add_op(16'(k), 8'($urandom), 16'($urandom),
                               9'($urandom_range(0, 500)), traffic_now));
            end
        end
        drain_outcomes();
    endtask

    initial begin
        clear_shadow_table();
        traffic_now = $urandom;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_add_then_tick();
        test_duplicate_and_full();
        test_wrap_flush_unused();
        test_random_traffic(25, 45, 90);
        traffic_now = 32'hFFFF_F000;
        test_random_traffic(45, 25, 90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_receiver_hold_off();
        test_random_traffic(0, 0, 90);

        $display("Sent %0d transactions and checked %0d results under three idle patterns",
                 ops_sent, results_seen);
        $display("and a long receiver hold-off: %0d deliveries, %0d adds stored, %0d refused.",
                 deliveries_seen, adds_stored, adds_refused);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
